[rtl/core/itoa_pkg.sv]
package itoa_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int MAG_WIDTH   = VALUE_WIDTH + 1;
    localparam int RADIX_WIDTH = 6;
    localparam int CHAR_WIDTH  = 8;
    localparam int COUNT_WIDTH = $clog2(VALUE_WIDTH + 1);
    localparam int INDEX_WIDTH = $clog2(VALUE_WIDTH);
    localparam int DIV_CNT_WIDTH = $clog2(MAG_WIDTH + 1);

    localparam logic [CHAR_WIDTH-1:0]  CHR_ZERO     = 8'h30;
    localparam logic [CHAR_WIDTH-1:0]  CHR_LETTER_A = 8'h61;
    localparam logic [CHAR_WIDTH-1:0]  CHR_MINUS    = 8'h2d;
    localparam logic [RADIX_WIDTH-1:0] DIGIT_MAX    = 6'd9;
    localparam logic [RADIX_WIDTH-1:0] DECIMAL      = 6'd10;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN    = 6'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX    = 6'd36;

    typedef struct packed {
        logic                   start;
        logic [MAG_WIDTH-1:0]   dividend;
        logic [RADIX_WIDTH-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [MAG_WIDTH-1:0]   quotient;
        logic [RADIX_WIDTH-1:0] remainder;
    } div_resp_t;

    // Register values outside 2..36 are clamped to the nearest legal base.
    function automatic logic [RADIX_WIDTH-1:0] effective_radix(
        input logic [RADIX_WIDTH-1:0] r
    );
        logic [RADIX_WIDTH-1:0] res;
        res = r;
        if (r < RADIX_MIN)
        begin
            res = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] digit_char(
        input logic [RADIX_WIDTH-1:0] d
    );
        logic [CHAR_WIDTH-1:0] d8;
        d8 = CHAR_WIDTH'(d);
        if (d > DIGIT_MAX)
        begin
            return d8 - CHAR_WIDTH'(DECIMAL) + CHR_LETTER_A;
        end
        return d8 + CHR_ZERO;
    endfunction

endpackage

[rtl/core/itoa_divider.sv]
module itoa_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  itoa_pkg::div_req_t  req,
    output itoa_pkg::div_resp_t resp
);

    logic [itoa_pkg::MAG_WIDTH-1:0]     quo_reg;
    logic [itoa_pkg::RADIX_WIDTH-1:0]   rem_reg;
    logic [itoa_pkg::DIV_CNT_WIDTH-1:0] cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;

    logic [itoa_pkg::RADIX_WIDTH:0]     trial;
    logic [itoa_pkg::RADIX_WIDTH:0]     diff;
    logic                               fits;
    logic [itoa_pkg::RADIX_WIDTH-1:0]   rem_next;

    // One quotient bit per cycle, restoring long division.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[itoa_pkg::MAG_WIDTH-1]};
        diff     = trial - {1'b0, req.divisor};
        fits     = trial >= {1'b0, req.divisor};
        rem_next = fits ? diff[itoa_pkg::RADIX_WIDTH-1:0]
                        : trial[itoa_pkg::RADIX_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= itoa_pkg::DIV_CNT_WIDTH'(itoa_pkg::MAG_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == itoa_pkg::DIV_CNT_WIDTH'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[itoa_pkg::MAG_WIDTH-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign resp.done      = done_reg;
    assign resp.quotient  = quo_reg;
    assign resp.remainder = rem_reg;

endmodule

[rtl/core/itoa_digit_store.sv]
module itoa_digit_store (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [itoa_pkg::INDEX_WIDTH-1:0] wr_addr,
    input  logic [itoa_pkg::RADIX_WIDTH-1:0] wr_data,
    input  logic [itoa_pkg::INDEX_WIDTH-1:0] rd_addr,
    output logic [itoa_pkg::RADIX_WIDTH-1:0] rd_data
);

    logic [itoa_pkg::RADIX_WIDTH-1:0] mem [itoa_pkg::VALUE_WIDTH];
    logic [itoa_pkg::RADIX_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/integer_to_ascii_radix.sv]
// Converts a 16-bit signed integer into ASCII text in the base held in the
// radix register (2 to 36, decimal after reset). The integer arrives as one
// transfer on the s_ channel; the characters leave on the m_ channel, most
// significant first, with m_tlast on the final one. Only in base 10 is a
// negative value shown as a minus sign and its magnitude; in other bases the
// bit pattern is read as unsigned. Letters for digits above 9 are lower case.
// The user writes the radix through radix_we/radix_wdata only while the
// block is idle; the block itself does not enforce this. Digits are found by
// one shared restoring divider that yields one quotient bit per cycle; each
// digit is a start, 17 bit steps and a write-back of the remainder. Each
// character then has two steps: a digit store read and the load of the
// output register, and a minus sign takes one more step. Zero skips the
// divider and writes its single digit straight into the digit store.
// s_tready is high only while no conversion is in progress; the block accepts
// the next integer while its last character still waits in the output
// register. When the receiver stalls, the output register holds its character
// and the sequencer waits. Reset clears the sequencer and output valid and
// sets the radix back to 10; the digit store needs no clearing.
module integer_to_ascii_radix (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        radix_we,
    input  logic [5:0]  radix_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] text_char
    output logic        m_tlast     // last_char
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_START = 6'b000010,
        ST_WAIT  = 6'b000100,
        ST_SIGN  = 6'b001000,
        ST_FETCH = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t                             state_reg, state_next;
    logic [itoa_pkg::RADIX_WIDTH-1:0]   radix_reg;
    logic [itoa_pkg::RADIX_WIDTH-1:0]   base_reg, base_next;
    logic                               neg_reg, neg_next;
    logic [itoa_pkg::MAG_WIDTH-1:0]     quot_reg, quot_next;
    logic [itoa_pkg::COUNT_WIDTH-1:0]   count_reg, count_next;
    logic [itoa_pkg::INDEX_WIDTH-1:0]   idx_reg, idx_next;
    logic                               out_valid_reg, out_valid_next;
    logic [itoa_pkg::CHAR_WIDTH-1:0]    out_char_reg, out_char_next;
    logic                               out_last_reg, out_last_next;

    logic [itoa_pkg::VALUE_WIDTH-1:0]   raw;
    logic [itoa_pkg::RADIX_WIDTH-1:0]   base_in;
    logic                               neg_in;
    logic [itoa_pkg::MAG_WIDTH-1:0]     mag_in;
    logic                               slot_free;
    logic                               accept;

    itoa_pkg::div_req_t                 div_req;
    itoa_pkg::div_resp_t                div_resp;

    logic                               st_wr_en;
    logic [itoa_pkg::INDEX_WIDTH-1:0]   st_wr_addr;
    logic [itoa_pkg::RADIX_WIDTH-1:0]   st_wr_data;
    logic [itoa_pkg::RADIX_WIDTH-1:0]   st_rd_data;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;

    always_comb
    begin
        raw     = s_tdata[itoa_pkg::VALUE_WIDTH-1:0];
        base_in = itoa_pkg::effective_radix(radix_reg);
        neg_in  = raw[itoa_pkg::VALUE_WIDTH-1] && (base_in == itoa_pkg::DECIMAL);
        // The magnitude is formed in one extra bit so the most negative value fits.
        if (neg_in)
        begin
            mag_in = (itoa_pkg::MAG_WIDTH'(1) << itoa_pkg::VALUE_WIDTH) - {1'b0, raw};
        end
        else
        begin
            mag_in = {1'b0, raw};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        neg_next       = neg_reg;
        quot_next      = quot_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        st_wr_en       = 1'b0;
        st_wr_addr     = count_reg[itoa_pkg::INDEX_WIDTH-1:0];
        st_wr_data     = div_resp.remainder;
        div_req.start    = 1'b0;
        div_req.dividend = quot_reg;
        div_req.divisor  = base_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    base_next = base_in;
                    neg_next  = neg_in;
                    quot_next = mag_in;
                    if (mag_in == '0)
                    begin
                        st_wr_en   = 1'b1;
                        st_wr_addr = '0;
                        st_wr_data = '0;
                        count_next = itoa_pkg::COUNT_WIDTH'(1);
                        idx_next   = '0;
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        count_next = '0;
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                div_req.start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_resp.done)
                begin
                    st_wr_en   = 1'b1;
                    count_next = count_reg + 1'b1;
                    quot_next  = div_resp.quotient;
                    if ((div_resp.quotient == '0) ||
                        (count_next == itoa_pkg::COUNT_WIDTH'(itoa_pkg::VALUE_WIDTH)))
                    begin
                        idx_next   = count_reg[itoa_pkg::INDEX_WIDTH-1:0];
                        state_next = neg_reg ? ST_SIGN : ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = itoa_pkg::CHR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = itoa_pkg::digit_char(st_rd_data);
                    out_last_next  = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radix_reg     <= itoa_pkg::DECIMAL;
            neg_reg       <= 1'b0;
            quot_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            quot_reg      <= quot_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (radix_we)
            begin
                radix_reg <= radix_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    itoa_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    itoa_digit_store u_digit_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_addr (idx_reg),
        .rd_data (st_rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

endmodule

[rtl/core/itoa_checker.sv]
module itoa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // A character that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output transfer withdrawn while stalled");

    // Once an integer is taken the block is busy with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again while converting");

    // A new integer is only taken when at most the final character waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !m_tvalid || m_tlast)
        else $error("input accepted with characters still pending");

    // A stalled character keeps its value and its last flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output transfer changed while stalled");

    // The minus sign is always followed by digits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata == itoa_pkg::CHR_MINUS) |-> !m_tlast)
        else $error("minus sign marked as last character");

endmodule

bind integer_to_ascii_radix itoa_checker u_itoa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

    import itoa_pkg::*;

    // Worst case per number: sixteen binary digits through the divider,
    // sixteen characters each waiting out a slow receiver, plus sender gaps.
    // Some 110 numbers at that cost stay well inside CYCLE_LIMIT.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          PHASES      = 12;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] text_char;
        logic                  last_char;
    } text_char_t;

    class itoa_scoreboard;
        logic [RADIX_WIDTH-1:0] radix_reg = DECIMAL;
        text_char_t             pending_chars[$];
        int                     errors = 0;

        function void log_error(string msg);
            errors++;
            if (errors <= 10)
            begin
                $display("MISMATCH at %0t: %s", $realtime, msg);
            end
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction

        // Works out the characters of one accepted number in the current base.
        function void note_value(logic [VALUE_WIDTH-1:0] v);
            logic [RADIX_WIDTH-1:0] base;
            logic [MAG_WIDTH-1:0]   mag;
            logic [RADIX_WIDTH-1:0] digits[$];
            logic                   negative;
            text_char_t             e;
            base = radix_reg;
            if (base < RADIX_MIN)
            begin
                base = RADIX_MIN;
            end
            else if (base > RADIX_MAX)
            begin
                base = RADIX_MAX;
            end
            negative = v[VALUE_WIDTH-1] && (base == DECIMAL);
            mag = negative ? (MAG_WIDTH'(1) << VALUE_WIDTH) - MAG_WIDTH'(v) : MAG_WIDTH'(v);
            if (mag == '0)
            begin
                digits.push_back('0);
            end
            while (mag != '0)
            begin
                digits.push_front(RADIX_WIDTH'(mag % MAG_WIDTH'(base)));
                mag = mag / MAG_WIDTH'(base);
            end
            if (negative)
            begin
                e.text_char = CHR_MINUS;
                e.last_char = 1'b0;
                pending_chars.push_back(e);
            end
            foreach (digits[i])
            begin
                if (digits[i] > DIGIT_MAX)
                begin
                    e.text_char = CHR_LETTER_A + CHAR_WIDTH'(digits[i] - DECIMAL);
                end
                else
                begin
                    e.text_char = CHR_ZERO + CHAR_WIDTH'(digits[i]);
                end
                e.last_char = (i == digits.size() - 1);
                pending_chars.push_back(e);
            end
        endfunction

        function void check_char(logic [CHAR_WIDTH-1:0] c, logic l);
            text_char_t e;
            if (pending_chars.size() == 0)
            begin
                log_error($sformatf("unexpected char 0x%02h last=%0b", c, l));
                return;
            end
            e = pending_chars.pop_front();
            if (c !== e.text_char)
            begin
                log_error($sformatf("char: expected 0x%02h, got 0x%02h", e.text_char, c));
            end
            if (l !== e.last_char)
            begin
                log_error($sformatf("last flag on 0x%02h: expected %0b, got %0b",
                                    e.text_char, e.last_char, l));
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   radix_we;
    logic [RADIX_WIDTH-1:0] radix_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [15:0]            s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;
    logic                   m_tlast;

    itoa_scoreboard sb = new();

    int unsigned tx_idle_pct = 7;
    int unsigned rx_idle_pct = 63;
    bit          hold_req    = 1'b0;
    int unsigned cycle_count = 0;

    integer_to_ascii_radix u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix_we    (radix_we),
        .radix_wdata (radix_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Offers one number and returns once it has been taken.
    task automatic send_value(input logic [15:0] v);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge clk);
        while (s_tready !== 1'b1)
        begin
            @(posedge clk);
        end
        sb.note_value(v);
    endtask

    // The base changes only once every character has come out.
    task automatic write_radix(input logic [RADIX_WIDTH-1:0] r);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        radix_we    <= 1'b1;
        radix_wdata <= r;
        @(posedge clk);
        radix_we <= 1'b0;
        sb.radix_reg = r;
    endtask

    // Receiver: checks each transfer and decides the next tready.
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
        begin
            @(posedge clk);
        end
        forever
        begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                sb.check_char(m_tdata, m_tlast);
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial
    begin
        logic [RADIX_WIDTH-1:0] phase_radix[PHASES];
        logic [RADIX_WIDTH-1:0] r;
        logic [15:0]            v;
        int                     count;
        phase_radix = '{6'd10, 6'd2, 6'd36, 6'd37, 6'd8, 6'd1,
                        6'd16, 6'd5, 6'd10, 6'd0, 6'd63, 6'd3};
        rst_n       <= 1'b0;
        radix_we    <= 1'b0;
        radix_wdata <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Decimal straight out of reset, including the most negative value.
        send_value(16'd0);
        send_value(16'd1);
        send_value(16'hffff);
        send_value(16'd9);
        send_value(16'd10);
        send_value(-16'sd10);
        send_value(16'h7fff);
        send_value(16'h8000);
        send_value(16'd12345);
        send_value(-16'sd9999);
        // A base below the legal range behaves as binary.
        write_radix(6'd0);
        send_value(16'hffff);
        send_value(16'h8000);
        send_value(16'h0001);
        write_radix(6'd1);
        send_value(16'h0005);
        // Base 36 reaches the letter z; negative values read as unsigned.
        write_radix(6'd36);
        send_value(16'd35);
        send_value(16'd36);
        send_value(16'hffff);
        send_value(16'h8000);
        // A base above the legal range behaves as base 36.
        write_radix(6'd63);
        send_value(16'h7fff);
        send_value(16'd0);
        write_radix(6'd16);
        send_value(16'hffff);
        send_value(16'habcd);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 4)
            begin
                tx_idle_pct = 63;
                rx_idle_pct = 7;
            end
            else if (p == 8)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            r = phase_radix[p];
            if (p == 7)
            begin
                r = RADIX_WIDTH'($urandom_range(3, 35));
            end
            else if (p == 11)
            begin
                r = RADIX_WIDTH'($urandom_range(0, 63));
            end
            write_radix(r);
            // Starve the output for a long stretch so the block backs up.
            if (p == 9)
            begin
                hold_req = 1'b1;
            end
            count = $urandom_range(6, 9);
            for (int i = 0; i < count; i++)
            begin
                case ($urandom_range(3))
                    0: v = 16'($urandom);
                    1: v = 16'($urandom_range(0, 40));
                    2: v = 16'($urandom_range(1, 40)) * 16'hffff;
                    default:
                    begin
                        case ($urandom_range(3))
                            0: v = 16'h0000;
                            1: v = 16'h8000;
                            2: v = 16'h7fff;
                            default: v = 16'hffff;
                        endcase
                    end
                endcase
                send_value(v);
            end
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
